FILE: design/ufrc_pkg.sv
// ============================================================================
// ufrc_pkg
// Shared types and constants of the UART frame receiver with checksum check.
// ============================================================================
package ufrc_pkg;

    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 6;
    localparam int CFG_INDEX_W = 2;

    // Frame header: checksum, command and length follow the preamble pair
    localparam logic [BYTE_W-1:0] HEADER_BYTES = 8'd4;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POSTAMBLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT   = 2'd2;

    localparam logic [BYTE_W-1:0] PREAMBLE_RESET  = 8'd254;
    localparam logic [BYTE_W-1:0] POSTAMBLE_RESET = 8'd253;
    localparam logic [BYTE_W-1:0] TIMEOUT_RESET   = 8'd10;

    typedef enum logic [1:0] {
        EV_GOOD    = 2'd0,
        EV_NACK    = 2'd1,
        EV_TIMEOUT = 2'd2
    } event_t;

    typedef struct packed {
        logic [BYTE_W-1:0] preamble;
        logic [BYTE_W-1:0] postamble;
        logic [BYTE_W-1:0] timeout;
    } cfg_t;

    // Frame close or timeout, handed from the decoder to the emitter
    typedef struct packed {
        logic              valid;
        event_t            kind;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] length;
        logic              has_payload;
        logic [IDX_W-1:0]  last_index;
    } frame_event_t;

    // Payload store write
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } store_write_t;

endpackage

FILE: design/uart_frame_receiver_checksum.sv
// ============================================================================
// uart_frame_receiver_checksum
// UART frame receiver with 8-bit checksum check and tick-based timeout.
// ============================================================================
// Usage:
//   Input stream (s_axis): one beat per received UART byte or per 1 ms tick.
//   tuser selects the kind (0 = byte in tdata, 1 = tick). Two preamble bytes
//   open a frame; checksum, command, length, payload and a postamble follow.
//   Output stream (m_axis): on a postamble that closes a good frame, one beat
//   per stored payload byte with tlast on the final one (an empty frame gives
//   one beat with payload_valid low); a checksum mismatch gives one NACK
//   beat; a timeout with a nonzero byte count gives one timeout beat.
//   Configuration: plain write port; index 0 preamble, 1 postamble, 2 timeout.
//   A closing beat loads the job register; each result beat is registered.
//   Throughput: one input beat per cycle while no burst is in flight. A burst
//   holds s_axis_tready low until its last result beat is issued, since
//   replay reads the payload store one entry per cycle unless m_axis stalls.
//   Reset: clears decoder state and job/output valid flags; restores register
//   defaults; the payload store is not cleared and needs no clearing pass.
//   Stall: a held output beat keeps its data; inputs are still taken as long
//   as no burst is pending.
// ============================================================================
module uart_frame_receiver_checksum
#(
    parameter int PAYLOAD_BYTES = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
    input  logic                                s_axis_tuser,  // [0] mode
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] command, [15:8] declared_length, [21:16] payload_index,
    // [29:22] payload_byte, [31:30] zero
    output logic [31:0]                         m_axis_tdata,
    // [1:0] event_res, [2] payload_valid
    output logic [2:0]                          m_axis_tuser,
    output logic                                m_axis_tlast,
    // configuration
    input  logic                                cfg_we,
    input  logic [ufrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ufrc_pkg::BYTE_W-1:0]         cfg_data
);
    import ufrc_pkg::*;

    cfg_t              cfg;
    frame_event_t      ev;
    store_write_t      wr;
    logic              busy;
    logic              beat;
    event_t            out_kind;
    logic [BYTE_W-1:0] out_command;
    logic [BYTE_W-1:0] out_length;
    logic [IDX_W-1:0]  out_index;
    logic [BYTE_W-1:0] out_byte;
    logic              out_pvalid;

    // Hold input only while a burst replays the payload store
    assign s_axis_tready = !busy;
    assign beat          = s_axis_tvalid && s_axis_tready;

    ufrc_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ufrc_decode #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (beat),
        .mode    (s_axis_tuser),
        .rx_byte (s_axis_tdata),
        .cfg     (cfg),
        .ev      (ev),
        .wr      (wr)
    );

    ufrc_emit #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_emit
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ev          (ev),
        .wr          (wr),
        .busy        (busy),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_kind    (out_kind),
        .out_command (out_command),
        .out_length  (out_length),
        .out_index   (out_index),
        .out_byte    (out_byte),
        .out_pvalid  (out_pvalid),
        .out_last    (m_axis_tlast)
    );

    // Pack result fields, lowest field first
    assign m_axis_tdata = {2'b00, out_byte, out_index, out_length, out_command};
    assign m_axis_tuser = {out_pvalid, out_kind};

endmodule

FILE: design/ufrc_regs.sv
// ============================================================================
// ufrc_regs
// Configuration registers: preamble, postamble and timeout tick count.
// ============================================================================
module ufrc_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ufrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ufrc_pkg::BYTE_W-1:0]         cfg_data,
    output ufrc_pkg::cfg_t                      cfg
);
    import ufrc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble  <= PREAMBLE_RESET;
            cfg_reg.postamble <= POSTAMBLE_RESET;
            cfg_reg.timeout   <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PREAMBLE:  cfg_reg.preamble  <= cfg_data;
                REG_POSTAMBLE: cfg_reg.postamble <= cfg_data;
                REG_TIMEOUT:   cfg_reg.timeout   <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/ufrc_decode.sv
// ============================================================================
// ufrc_decode
// Frame tracker: updates receiver state on each accepted beat, writes
// payload bytes to the store and flags frame closes and timeouts.
// ============================================================================
module ufrc_decode
#(
    parameter int PAYLOAD_BYTES = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            beat,
    input  logic                            mode,
    input  logic [ufrc_pkg::BYTE_W-1:0]     rx_byte,
    input  ufrc_pkg::cfg_t                  cfg,
    output ufrc_pkg::frame_event_t          ev,
    output ufrc_pkg::store_write_t          wr
);
    import ufrc_pkg::*;

    localparam logic [BYTE_W-1:0] PAYLOAD_LIMIT = BYTE_W'(PAYLOAD_BYTES);

    logic              in_frame_reg,       in_frame_next;
    logic [BYTE_W-1:0] byte_count_reg,     byte_count_next;
    logic [BYTE_W-1:0] running_sum_reg,    running_sum_next;
    logic [BYTE_W-1:0] sent_checksum_reg,  sent_checksum_next;
    logic [BYTE_W-1:0] stored_command_reg, stored_command_next;
    logic [BYTE_W-1:0] stored_length_reg,  stored_length_next;
    logic [BYTE_W-1:0] previous_byte_reg,  previous_byte_next;
    logic [BYTE_W-1:0] idle_ticks_reg,     idle_ticks_next;

    logic [BYTE_W-1:0] count_inc;
    logic [BYTE_W-1:0] pos;
    logic              past_header;
    logic              close_frame;
    logic              take_byte;

    assign count_inc   = byte_count_reg + 8'd1;
    assign pos         = count_inc - HEADER_BYTES;
    assign past_header = (count_inc >= HEADER_BYTES);
    assign close_frame = in_frame_reg && past_header && (rx_byte == cfg.postamble)
                         && (stored_length_reg == pos);
    assign take_byte   = in_frame_reg && past_header && !close_frame
                         && (pos < PAYLOAD_LIMIT);

    always_comb
    begin
        in_frame_next       = in_frame_reg;
        byte_count_next     = byte_count_reg;
        running_sum_next    = running_sum_reg;
        sent_checksum_next  = sent_checksum_reg;
        stored_command_next = stored_command_reg;
        stored_length_next  = stored_length_reg;
        previous_byte_next  = previous_byte_reg;
        idle_ticks_next     = idle_ticks_reg;
        ev                  = '0;
        wr.en               = 1'b0;
        wr.addr             = pos[IDX_W-1:0];
        wr.data             = rx_byte;

        if (beat && mode == MODE_TICK)
        begin
            if (byte_count_reg != '0 && idle_ticks_reg >= cfg.timeout)
            begin
                // abandon the partial frame
                idle_ticks_next    = '0;
                byte_count_next    = '0;
                running_sum_next   = '0;
                in_frame_next      = 1'b0;
                previous_byte_next = '0;
                ev.valid           = 1'b1;
                ev.kind            = EV_TIMEOUT;
            end
            else if (byte_count_reg != '0 && idle_ticks_reg != 8'hFF)
            begin
                idle_ticks_next = idle_ticks_reg + 8'd1;
            end
        end
        else if (beat)
        begin
            byte_count_next    = count_inc;
            idle_ticks_next    = '0;
            previous_byte_next = rx_byte;
            if (in_frame_reg)
            begin
                if (close_frame)
                begin
                    in_frame_next   = 1'b0;
                    byte_count_next = '0;
                    ev.valid        = 1'b1;
                    ev.command      = stored_command_reg;
                    ev.length       = stored_length_reg;
                    if (sent_checksum_reg != running_sum_reg)
                    begin
                        ev.kind = EV_NACK;
                    end
                    else
                    begin
                        ev.kind = EV_GOOD;
                        if (stored_length_reg != '0)
                        begin
                            ev.has_payload = 1'b1;
                            ev.last_index  = (stored_length_reg < PAYLOAD_LIMIT)
                                ? stored_length_reg[IDX_W-1:0] - 6'd1
                                : PAYLOAD_LIMIT[IDX_W-1:0] - 6'd1;
                        end
                    end
                end
                else if (count_inc == 8'd1)
                begin
                    sent_checksum_next = rx_byte;
                end
                else if (count_inc == 8'd2)
                begin
                    stored_command_next = rx_byte;
                    running_sum_next    = rx_byte;
                end
                else if (count_inc == 8'd3)
                begin
                    stored_length_next = rx_byte;
                    running_sum_next   = running_sum_reg + rx_byte;
                end
                else if (take_byte)
                begin
                    wr.en            = 1'b1;
                    running_sum_next = running_sum_reg + rx_byte;
                end
            end
            else if (rx_byte == cfg.preamble && previous_byte_reg == cfg.preamble)
            begin
                in_frame_next    = 1'b1;
                byte_count_next  = '0;
                running_sum_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg       <= 1'b0;
            byte_count_reg     <= '0;
            running_sum_reg    <= '0;
            sent_checksum_reg  <= '0;
            stored_command_reg <= '0;
            stored_length_reg  <= '0;
            previous_byte_reg  <= '0;
            idle_ticks_reg     <= '0;
        end
        else
        begin
            in_frame_reg       <= in_frame_next;
            byte_count_reg     <= byte_count_next;
            running_sum_reg    <= running_sum_next;
            sent_checksum_reg  <= sent_checksum_next;
            stored_command_reg <= stored_command_next;
            stored_length_reg  <= stored_length_next;
            previous_byte_reg  <= previous_byte_next;
            idle_ticks_reg     <= idle_ticks_next;
        end
    end

endmodule

FILE: design/ufrc_emit.sv
// ============================================================================
// ufrc_emit
// Payload store and result sequencer: replays a closed frame or timeout one
// beat per cycle, unless the output stalls, through the output register.
// ============================================================================
module ufrc_emit
#(
    parameter int PAYLOAD_BYTES = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  ufrc_pkg::frame_event_t          ev,
    input  ufrc_pkg::store_write_t          wr,
    output logic                            busy,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ufrc_pkg::event_t                out_kind,
    output logic [ufrc_pkg::BYTE_W-1:0]     out_command,
    output logic [ufrc_pkg::BYTE_W-1:0]     out_length,
    output logic [ufrc_pkg::IDX_W-1:0]      out_index,
    output logic [ufrc_pkg::BYTE_W-1:0]     out_byte,
    output logic                            out_pvalid,
    output logic                            out_last
);
    import ufrc_pkg::*;

    localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    logic [BYTE_W-1:0] mem [PAYLOAD_BYTES];

    // active job
    logic              job_active_reg;
    event_t            job_kind_reg;
    logic [BYTE_W-1:0] job_command_reg;
    logic [BYTE_W-1:0] job_length_reg;
    logic              job_payload_reg;
    logic [IDX_W-1:0]  job_last_reg;
    logic [IDX_W-1:0]  job_idx_reg;

    // output register
    logic              out_valid_reg;
    event_t            out_kind_reg;
    logic [BYTE_W-1:0] out_command_reg;
    logic [BYTE_W-1:0] out_length_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic [BYTE_W-1:0] mem_q_reg;
    logic              out_pvalid_reg;
    logic              out_last_reg;

    logic issue;
    logic issue_last;

    assign issue      = job_active_reg && (!out_valid_reg || out_ready);
    assign issue_last = (job_idx_reg == job_last_reg);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_active_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ev.valid)
            begin
                job_active_reg <= 1'b1;
            end
            else if (issue && issue_last)
            begin
                job_active_reg <= 1'b0;
            end

            if (issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev.valid)
        begin
            job_kind_reg    <= ev.kind;
            job_command_reg <= ev.command;
            job_length_reg  <= ev.length;
            job_payload_reg <= ev.has_payload;
            job_last_reg    <= ev.last_index;
            job_idx_reg     <= '0;
        end
        else if (issue)
        begin
            job_idx_reg <= job_idx_reg + 6'd1;
        end

        if (issue)
        begin
            out_kind_reg    <= job_kind_reg;
            out_command_reg <= job_command_reg;
            out_length_reg  <= job_length_reg;
            out_index_reg   <= job_idx_reg;
            out_pvalid_reg  <= job_payload_reg;
            out_last_reg    <= issue_last;
            mem_q_reg       <= mem[job_idx_reg[AW-1:0]];
        end
    end

    assign busy        = job_active_reg;
    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_command = out_command_reg;
    assign out_length  = out_length_reg;
    assign out_index   = out_index_reg;
    assign out_byte    = out_pvalid_reg ? mem_q_reg : '0;
    assign out_pvalid  = out_pvalid_reg;
    assign out_last    = out_last_reg;

`ifndef SYNTHESIS
    a_no_store_write_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        job_active_reg |-> !wr.en)
        else $error("payload store written during a burst");

    a_no_event_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        job_active_reg |-> !ev.valid)
        else $error("frame event while a burst is active");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> job_active_reg)
        else $error("burst ended without a last beat");

    a_payload_only_good: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_pvalid_reg) |-> (out_kind_reg == EV_GOOD))
        else $error("payload beat on a non-good event");
`endif

endmodule
